// ===== src/tpm_pkg.sv =====
// Package for the tree path maximum / minimum block.
// Holds sizes, the lifting table row type, the sequencer states and the address function.
package tpm_pkg;

  localparam int NODES       = 1024;
  localparam int NODE_W      = 10;
  localparam int LEVELS      = 10;
  localparam int LVL_W       = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int W_BITS      = 32;
  localparam int TDEPTH      = LEVELS * NODES;
  localparam int TADDR_W     = $clog2(TDEPTH);
  localparam int DEPTH_MAX   = NODES - 1;

  typedef struct packed {
    logic [NODE_W-1:0] anc;
    logic [W_BITS-1:0] mx;
    logic [W_BITS-1:0] mn;
  } entry_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_I_BASE,
    S_I_RDU,
    S_I_RDM,
    S_I_WR,
    S_Q_DU,
    S_Q_DV,
    S_Q1_RD,
    S_Q1_DP,
    S_Q1_CMP,
    S_Q2_START,
    S_Q2_RU,
    S_Q2_RV,
    S_Q2_CMP,
    S_Q3_RU,
    S_Q3_RV,
    S_Q3_CMP,
    S_Q_OUT
  } state_e;

  function automatic logic [TADDR_W-1:0] taddr(input logic [LVL_W-1:0] lvl,
                                               input logic [NODE_W-1:0] n);
    int a;
    a = int'(lvl) * NODES + int'(n);
    return a[TADDR_W-1:0];
  endfunction

endpackage

// ===== src/tpm_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; no package needed.
module tpm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== src/tpm_alu.sv =====
// Shared maximum / minimum unit folding two table rows into a running pair.
// Depends on tpm_pkg for the weight width.
module tpm_alu import tpm_pkg::*; (
  input  logic [W_BITS-1:0] hi_i,
  input  logic [W_BITS-1:0] lo_i,
  input  logic [W_BITS-1:0] a_mx_i,
  input  logic [W_BITS-1:0] a_mn_i,
  input  logic [W_BITS-1:0] b_mx_i,
  input  logic [W_BITS-1:0] b_mn_i,
  output logic [W_BITS-1:0] hi_o,
  output logic [W_BITS-1:0] lo_o
);

  logic [W_BITS-1:0] mx_ab;
  logic [W_BITS-1:0] mn_ab;

  always_comb begin
    mx_ab = (a_mx_i > b_mx_i) ? a_mx_i : b_mx_i;
    mn_ab = (a_mn_i < b_mn_i) ? a_mn_i : b_mn_i;
    hi_o  = (hi_i > mx_ab) ? hi_i : mx_ab;
    lo_o  = (lo_i < mn_ab) ? lo_i : mn_ab;
  end

endmodule

// ===== src/tree_path_max_min_edge.sv =====
// Tree path max/min edge: binary-lifting tables with path queries.
// An insert writes the base row and then builds each higher level in turn; a query
// climbs the levels with reads through the single read port of the lifting table RAM.
// One item is in work at a time; a finished result waits in the output register.
// Reset (asynchronous, active low) clears only control state; the tables are
// undefined until written, so no clearing pass is run.
module tree_path_max_min_edge import tpm_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              mode_i,
  input  logic [9:0]        node_a_i,
  input  logic [9:0]        node_b_i,
  input  logic [31:0]       weight_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [31:0]       max_weight_o,
  output logic [31:0]       min_weight_o,
  output logic              same_node_o
);

  state_e state_q, state_d;

  // Working registers of the item in flight.
  logic [NODE_W-1:0] u_q, u_d, v_q, v_d;
  logic [W_BITS-1:0] w_q, w_d;
  logic              root_q, root_d;
  logic [NODE_W-1:0] dv_q, dv_d;
  logic [W_BITS-1:0] hi_q, hi_d, lo_q, lo_d;
  logic [LVL_W-1:0]  lvl_q, lvl_d;
  entry_t            row_q, row_d;
  logic              same_q, same_d;

  // Output register.
  logic              out_vld_q, out_vld_d;
  logic [W_BITS-1:0] omax_q, omax_d, omin_q, omin_d;
  logic              osame_q, osame_d;

  // Memory ports.
  logic               t_we;
  logic [TADDR_W-1:0] t_waddr, t_raddr;
  entry_t             t_wdata, t_rdata;
  logic               d_we;
  logic [NODE_W-1:0]  d_waddr, d_raddr, d_wdata, d_rdata;

  // Shared max/min unit.
  logic [W_BITS-1:0] alu_hi, alu_lo, alu_amx, alu_amn, alu_bmx, alu_bmn;
  logic [W_BITS-1:0] alu_hi_o, alu_lo_o;

  logic accept;
  logic out_free;
  logic last_lvl;
  logic deep_ok;

  tpm_ram #(.WIDTH($bits(entry_t)), .DEPTH(TDEPTH)) u_tab (
    .clk_i   (clk_i),
    .we_i    (t_we),
    .waddr_i (t_waddr),
    .wdata_i (t_wdata),
    .raddr_i (t_raddr),
    .rdata_o (t_rdata)
  );

  tpm_ram #(.WIDTH(NODE_W), .DEPTH(NODES)) u_dep (
    .clk_i   (clk_i),
    .we_i    (d_we),
    .waddr_i (d_waddr),
    .wdata_i (d_wdata),
    .raddr_i (d_raddr),
    .rdata_o (d_rdata)
  );

  tpm_alu u_alu (
    .hi_i   (alu_hi),
    .lo_i   (alu_lo),
    .a_mx_i (alu_amx),
    .a_mn_i (alu_amn),
    .b_mx_i (alu_bmx),
    .b_mn_i (alu_bmn),
    .hi_o   (alu_hi_o),
    .lo_o   (alu_lo_o)
  );

  assign in_stall_o   = (state_q != S_IDLE);
  assign accept       = in_valid_i && (state_q == S_IDLE);
  assign out_free     = !out_vld_q || !out_stall_i;
  assign out_valid_o  = out_vld_q;
  assign max_weight_o = omax_q;
  assign min_weight_o = omin_q;
  assign same_node_o  = osame_q;

  // lvl_q doubles as the insert level and the query level counter.
  assign last_lvl = (lvl_q == LVL_W'(LEVELS - 1));
  assign deep_ok  = (d_rdata >= dv_q);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (!mode_i) begin
            state_d = S_I_BASE;
          end else if (node_a_i == node_b_i) begin
            state_d = S_Q_OUT;
          end else begin
            state_d = S_Q_DU;
          end
        end
      end
      S_I_BASE:   state_d = (LEVELS == 1) ? S_IDLE : S_I_RDU;
      S_I_RDU:    state_d = S_I_RDM;
      S_I_RDM:    state_d = S_I_WR;
      S_I_WR:     state_d = last_lvl ? S_IDLE : S_I_RDU;
      S_Q_DU:     state_d = S_Q_DV;
      S_Q_DV:     state_d = S_Q1_RD;
      S_Q1_RD:    state_d = (u_q == v_q) ? S_Q_OUT : S_Q1_DP;
      S_Q1_DP:    state_d = S_Q1_CMP;
      S_Q1_CMP:   state_d = (lvl_q == '0) ? S_Q2_START : S_Q1_RD;
      S_Q2_START: state_d = (u_q == v_q) ? S_Q_OUT : S_Q2_RU;
      S_Q2_RU:    state_d = S_Q2_RV;
      S_Q2_RV:    state_d = S_Q2_CMP;
      S_Q2_CMP:   state_d = (lvl_q == '0) ? S_Q3_RU : S_Q2_RU;
      S_Q3_RU:    state_d = S_Q3_RV;
      S_Q3_RV:    state_d = S_Q3_CMP;
      S_Q3_CMP:   state_d = S_Q_OUT;
      S_Q_OUT:    state_d = out_free ? S_IDLE : S_Q_OUT;
      default:    state_d = S_IDLE;
    endcase
  end

  // Datapath and memory controls.
  always_comb begin
    u_d = u_q; v_d = v_q; w_d = w_q; root_d = root_q; dv_d = dv_q;
    hi_d = hi_q; lo_d = lo_q; lvl_d = lvl_q; row_d = row_q; same_d = same_q;
    out_vld_d = out_vld_q && out_stall_i;
    omax_d = omax_q; omin_d = omin_q; osame_d = osame_q;

    t_we = 1'b0; t_waddr = '0; t_wdata = row_q; t_raddr = '0;
    d_we = 1'b0; d_waddr = u_q; d_wdata = '0; d_raddr = '0;

    alu_hi = hi_q; alu_lo = lo_q;
    alu_amx = row_q.mx; alu_amn = row_q.mn;
    alu_bmx = row_q.mx; alu_bmn = row_q.mn;

    unique case (state_q)
      S_IDLE: begin
        d_raddr = mode_i ? node_a_i : node_b_i;
        if (accept) begin
          u_d    = node_a_i;
          v_d    = node_b_i;
          w_d    = weight_i[W_BITS-1:0];
          root_d = (node_a_i == node_b_i);
          same_d = (node_a_i == node_b_i);
          hi_d   = '0;
          lo_d   = '0;
        end
      end
      S_I_BASE: begin
        d_we    = 1'b1;
        d_waddr = u_q;
        t_we    = 1'b1;
        t_waddr = taddr('0, u_q);
        if (root_q) begin
          d_wdata = '0;
          t_wdata = '{anc: u_q, mx: '0, mn: '1};
        end else begin
          d_wdata = (d_rdata >= NODE_W'(DEPTH_MAX)) ? NODE_W'(DEPTH_MAX)
                                                    : d_rdata + NODE_W'(1);
          t_wdata = '{anc: v_q, mx: w_q, mn: w_q};
        end
        lvl_d = LVL_W'(1);
      end
      S_I_RDU: begin
        t_raddr = taddr(lvl_q - LVL_W'(1), u_q);
      end
      S_I_RDM: begin
        row_d   = t_rdata;
        t_raddr = taddr(lvl_q - LVL_W'(1), t_rdata.anc);
      end
      S_I_WR: begin
        alu_hi  = row_q.mx;
        alu_lo  = row_q.mn;
        alu_amx = t_rdata.mx; alu_amn = t_rdata.mn;
        alu_bmx = t_rdata.mx; alu_bmn = t_rdata.mn;
        t_we    = 1'b1;
        t_waddr = taddr(lvl_q, u_q);
        t_wdata = '{anc: t_rdata.anc, mx: alu_hi_o, mn: alu_lo_o};
        lvl_d   = lvl_q + LVL_W'(1);
      end
      S_Q_DU: begin
        d_raddr = v_q;
        dv_d    = d_rdata;
      end
      S_Q_DV: begin
        // Keep the deeper endpoint in u; dv holds the shallower depth.
        if (dv_q < d_rdata) begin
          u_d = v_q;
          v_d = u_q;
        end else begin
          dv_d = d_rdata;
        end
        hi_d  = '0;
        lo_d  = '1;
        lvl_d = LVL_W'(LEVELS - 1);
      end
      S_Q1_RD: begin
        t_raddr = taddr(lvl_q, u_q);
      end
      S_Q1_DP: begin
        row_d   = t_rdata;
        d_raddr = t_rdata.anc;
      end
      S_Q1_CMP: begin
        if (deep_ok) begin
          hi_d = alu_hi_o;
          lo_d = alu_lo_o;
          u_d  = row_q.anc;
        end
        lvl_d = lvl_q - LVL_W'(1);
      end
      S_Q2_START: begin
        lvl_d = LVL_W'(LEVELS - 1);
      end
      S_Q2_RU: begin
        t_raddr = taddr(lvl_q, u_q);
      end
      S_Q2_RV: begin
        row_d   = t_rdata;
        t_raddr = taddr(lvl_q, v_q);
      end
      S_Q2_CMP: begin
        alu_bmx = t_rdata.mx;
        alu_bmn = t_rdata.mn;
        if (row_q.anc != t_rdata.anc) begin
          hi_d = alu_hi_o;
          lo_d = alu_lo_o;
          u_d  = row_q.anc;
          v_d  = t_rdata.anc;
        end
        lvl_d = lvl_q - LVL_W'(1);
      end
      S_Q3_RU: begin
        t_raddr = taddr('0, u_q);
      end
      S_Q3_RV: begin
        row_d   = t_rdata;
        t_raddr = taddr('0, v_q);
      end
      S_Q3_CMP: begin
        alu_bmx = t_rdata.mx;
        alu_bmn = t_rdata.mn;
        hi_d    = alu_hi_o;
        lo_d    = alu_lo_o;
      end
      S_Q_OUT: begin
        if (out_free) begin
          out_vld_d = 1'b1;
          omax_d    = same_q ? '0 : hi_q;
          omin_d    = same_q ? '0 : lo_q;
          osame_d   = same_q;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    u_q     <= u_d;
    v_q     <= v_d;
    w_q     <= w_d;
    root_q  <= root_d;
    dv_q    <= dv_d;
    hi_q    <= hi_d;
    lo_q    <= lo_d;
    lvl_q   <= lvl_d;
    row_q   <= row_d;
    same_q  <= same_d;
    omax_q  <= omax_d;
    omin_q  <= omin_d;
    osame_q <= osame_d;
  end

endmodule
